// ===== rtl/rttt_pkg.sv =====
package rttt_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;
  localparam int unsigned RESULT_CAP = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] task_tag;
    logic [31:0] task_arg;
    logic [31:0] interval;
    logic [15:0] repeat_count;
    logic [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_index;
    logic [15:0] fired_tag;
    logic [31:0] fired_arg;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1
  } state_t;

endpackage

// ===== rtl/rttt_cmd_queue.sv =====
module rttt_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rttt_pkg::in_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output rttt_pkg::in_item_t pop_data
);

  rttt_pkg::in_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |=> !(count == 2'd2))
    else $error("queue jumped from empty to full");
`endif

endmodule

// ===== rtl/rttt_engine.sv =====
module rttt_engine #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  rttt_pkg::in_item_t  cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  output rttt_pkg::out_item_t res,
  input  logic                res_ready
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] active;
  logic [15:0] tag_store      [SLOTS];
  logic [31:0] arg_store      [SLOTS];
  logic [31:0] interval_store [SLOTS];
  logic [15:0] repeat_store   [SLOTS];
  logic [15:0] fire_count     [SLOTS];
  logic [31:0] remaining      [SLOTS];

  rttt_pkg::state_t state, state_next;
  logic [IW-1:0] idx;
  logic [3:0]    nres;
  logic [IW-1:0] found_idx;

  logic [31:0]   rem_dec;
  logic          fires;
  logic          reload;
  logic          later_fire;
  logic          walk_step;
  logic          at_end;
  logic          take;
  logic [IW-1:0] free_idx;
  logic          free_any;
  logic          emit;
  rttt_pkg::out_item_t emit_item;
  logic          outbuf_free;

  assign at_end  = (idx == IW'(SLOTS - 1));
  assign rem_dec = (remaining[idx] != 32'd0) ? remaining[idx] - 32'd1 : 32'd0;
  assign fires   = active[idx] && (rem_dec == 32'd0);
  assign reload  = (repeat_store[idx] == rttt_pkg::REPEAT_FOREVER) ||
                   ((repeat_store[idx] != 16'd0) &&
                    ({1'b0, fire_count[idx]} < {1'b0, repeat_store[idx]} - 17'd1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // look ahead for a later slot that fires on this tick
  always_comb begin
    later_fire = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (IW'(j) > idx && active[j] && remaining[j][31:1] == 31'd0) begin
        later_fire = 1'b1;
      end
    end
  end

  assign outbuf_free = !res_valid || res_ready;
  assign take = (state == rttt_pkg::ST_IDLE) && !cmd_empty && outbuf_free;

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    walk_step  = 1'b0;
    emit       = 1'b0;
    emit_item  = '0;
    case (state)
      rttt_pkg::ST_IDLE: begin
        if (take) begin
          case (cmd.op)
            rttt_pkg::OP_TICK: begin
              state_next = rttt_pkg::ST_WALK;
            end
            rttt_pkg::OP_START: begin
              emit = 1'b1;
              emit_item.last = 1'b1;
              emit_item.kind = free_any ? rttt_pkg::KIND_START : rttt_pkg::KIND_ERROR;
              emit_item.slot_index = free_any ? 4'(free_idx) : 4'd0;
              if (free_any && free_idx != IW'(SLOTS - 1)) begin
                state_next = rttt_pkg::ST_WALK;
              end else begin
                cmd_pop = 1'b1;
              end
            end
            rttt_pkg::OP_CANCEL: begin
              emit = 1'b1;
              emit_item.last = 1'b1;
              emit_item.kind = ({1'b0, cmd.slot} >= 5'(SLOTS)) ?
                               rttt_pkg::KIND_ERROR : rttt_pkg::KIND_CANCEL;
              emit_item.slot_index = cmd.slot;
              cmd_pop = 1'b1;
            end
            default: begin
              emit = 1'b1;
              emit_item.last = 1'b1;
              emit_item.kind = rttt_pkg::KIND_ERROR;
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      rttt_pkg::ST_WALK: begin
        if (cmd.op == rttt_pkg::OP_TICK) begin
          if (!fires || nres == 4'(rttt_pkg::RESULT_CAP) || outbuf_free) begin
            walk_step = 1'b1;
            if (fires && nres != 4'(rttt_pkg::RESULT_CAP)) begin
              emit = 1'b1;
              emit_item.kind = rttt_pkg::KIND_FIRED;
              emit_item.slot_index = 4'(idx);
              emit_item.fired_tag = tag_store[idx];
              emit_item.fired_arg = arg_store[idx];
              emit_item.last = !later_fire ||
                               (nres == 4'(rttt_pkg::RESULT_CAP - 1));
            end
          end
        end else begin
          walk_step = 1'b1;
        end
        if (walk_step && at_end) begin
          cmd_pop = 1'b1;
          state_next = rttt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rttt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rttt_pkg::ST_IDLE;
      active <= '0;
      idx <= '0;
      nres <= '0;
      found_idx <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
        res <= emit_item;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        nres <= '0;
        if (cmd.op == rttt_pkg::OP_START && free_any) begin
          active[free_idx] <= 1'b1;
          tag_store[free_idx] <= cmd.task_tag;
          arg_store[free_idx] <= cmd.task_arg;
          interval_store[free_idx] <= cmd.interval;
          repeat_store[free_idx] <= cmd.repeat_count;
          fire_count[free_idx] <= 16'd0;
          remaining[free_idx] <= cmd.interval;
          found_idx <= free_idx;
          idx <= free_idx + IW'(1);
        end else begin
          idx <= '0;
        end
        if (cmd.op == rttt_pkg::OP_CANCEL && {1'b0, cmd.slot} < 5'(SLOTS)) begin
          active[cmd.slot[IW-1:0]] <= 1'b0;
          fire_count[cmd.slot[IW-1:0]] <= 16'd0;
        end
      end
      if (walk_step) begin
        if (emit) nres <= nres + 4'd1;
        if (!at_end) idx <= idx + IW'(1);
        if (cmd.op == rttt_pkg::OP_TICK) begin
          if (active[idx]) begin
            if (fires) begin
              if (reload) begin
                fire_count[idx] <= fire_count[idx] + 16'd1;
                remaining[idx] <= interval_store[idx];
              end else begin
                active[idx] <= 1'b0;
              end
            end else begin
              remaining[idx] <= rem_dec;
            end
          end
        end else if (active[idx] && tag_store[idx] == tag_store[found_idx]) begin
          active[idx] <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_ends: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == rttt_pkg::ST_IDLE)
    else $error("command retired outside idle return");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= 4'(rttt_pkg::RESULT_CAP))
    else $error("result cap exceeded");
  a_walk_cmd: assert property (@(posedge clk) disable iff (rst)
    state == rttt_pkg::ST_WALK |-> !cmd_empty)
    else $error("walk without command");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("waiting result changed");
`endif

endmodule

// ===== rtl/rttt_out_queue.sv =====
module rttt_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rttt_pkg::out_item_t in_data,
  output logic                in_ready,
  output logic                empty,
  output rttt_pkg::out_item_t data,
  input  logic                pop
);

  rttt_pkg::out_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic full;
  logic do_push;
  logic do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign in_ready = !full;
  assign do_push  = in_valid && !full;
  assign do_pop   = pop && !empty;
  assign data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("result queue pointers disagree with count");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data)))
    else $error("result dropped");
`endif

endmodule

// ===== rtl/repeating_task_timer_table_unit.sv =====
// A start, cancel or unused op result passes the command queue, the engine's result
// register and the result queue. A tick walks every slot in order; a start walks the slots
// after the one it takes. The engine finishes one command before it takes the next.
// A full result queue stalls the walk; a two-entry queue holds items meanwhile.
// Reset (rst, synchronous): every slot free, both queues empty.
module repeating_task_timer_table_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rttt_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rttt_pkg::out_item_t out_item
);

  logic                cmd_empty;
  logic                cmd_pop;
  rttt_pkg::in_item_t  cmd;
  logic                res_valid;
  rttt_pkg::out_item_t res;
  logic                res_ready;

  rttt_cmd_queue u_cmd (
    .clk(clk), .rst(rst),
    .push(push), .push_data(in_item), .full(full),
    .pop(cmd_pop), .empty(cmd_empty), .pop_data(cmd)
  );

  rttt_engine #(.SLOTS(SLOTS)) u_eng (
    .clk(clk), .rst(rst),
    .cmd_empty(cmd_empty), .cmd(cmd), .cmd_pop(cmd_pop),
    .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  rttt_out_queue u_out (
    .clk(clk), .rst(rst),
    .in_valid(res_valid), .in_data(res), .in_ready(res_ready),
    .empty(empty), .data(out_item), .pop(pop)
  );

endmodule

// ===== tb/tb_repeating_task_timer_table_unit.sv =====
`timescale 1ns / 100ps

class timer_table_scoreboard;
  localparam int NSLOT = 8;
  bit          act[NSLOT];
  logic [15:0] tag_q[NSLOT];
  logic [31:0] arg_q[NSLOT];
  logic [31:0] ivl_q[NSLOT];
  logic [15:0] rep_q[NSLOT];
  logic [15:0] fires[NSLOT];
  logic [31:0] count_down[NSLOT];
  rttt_pkg::out_item_t expected_results[$];
  int          fails;

  function void add_result(rttt_pkg::kind_t k, logic [3:0] idx, logic [15:0] tg,
                           logic [31:0] ag);
    rttt_pkg::out_item_t r;
    r.kind = k;
    r.slot_index = idx;
    r.fired_tag = tg;
    r.fired_arg = ag;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function void note_transfer(rttt_pkg::in_item_t it);
    int n;
    int found;
    int nfire;
    n = expected_results.size();
    found = -1;
    nfire = 0;
    case (rttt_pkg::op_t'(it.op))
      rttt_pkg::OP_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!act[i]) continue;
          if (count_down[i] != 0) count_down[i] = count_down[i] - 1;
          if (count_down[i] != 0) continue;
          if (nfire < rttt_pkg::RESULT_CAP) begin
            add_result(rttt_pkg::KIND_FIRED, 4'(i), tag_q[i], arg_q[i]);
            nfire++;
          end
          if (rep_q[i] == rttt_pkg::REPEAT_FOREVER ||
              (rep_q[i] != 0 && 32'(fires[i]) < 32'(rep_q[i]) - 1)) begin
            fires[i] = fires[i] + 16'd1;
            count_down[i] = ivl_q[i];
          end else begin
            act[i] = 0;
          end
        end
      end
      rttt_pkg::OP_START: begin
        for (int i = 0; i < NSLOT && found < 0; i++) begin
          if (!act[i]) found = i;
        end
        if (found < 0) begin
          add_result(rttt_pkg::KIND_ERROR, 4'd0, 16'd0, 32'd0);
        end else begin
          act[found] = 1;
          tag_q[found] = it.task_tag;
          arg_q[found] = it.task_arg;
          ivl_q[found] = it.interval;
          rep_q[found] = it.repeat_count;
          fires[found] = 0;
          count_down[found] = it.interval;
          for (int j = found + 1; j < NSLOT; j++) begin
            if (act[j] && tag_q[j] == it.task_tag) act[j] = 0;
          end
          add_result(rttt_pkg::KIND_START, 4'(found), 16'd0, 32'd0);
        end
      end
      rttt_pkg::OP_CANCEL: begin
        if (it.slot >= NSLOT) begin
          add_result(rttt_pkg::KIND_ERROR, it.slot, 16'd0, 32'd0);
        end else begin
          act[it.slot] = 0;
          fires[it.slot] = 0;
          add_result(rttt_pkg::KIND_CANCEL, it.slot, 16'd0, 32'd0);
        end
      end
      default: add_result(rttt_pkg::KIND_ERROR, 4'd0, 16'd0, 32'd0);
    endcase
    if (expected_results.size() > n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function void check_result(rttt_pkg::out_item_t got);
    rttt_pkg::out_item_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fails++;
      return;
    end
    e = expected_results.pop_front();
    if (got.kind !== e.kind) begin
      $display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
      fails++;
    end
    if (got.slot_index !== e.slot_index) begin
      $display("%0t: slot_index exp %0d got %0d", $time, e.slot_index, got.slot_index);
      fails++;
    end
    if (got.fired_tag !== e.fired_tag) begin
      $display("%0t: fired_tag exp %h got %h", $time, e.fired_tag, got.fired_tag);
      fails++;
    end
    if (got.fired_arg !== e.fired_arg) begin
      $display("%0t: fired_arg exp %h got %h", $time, e.fired_arg, got.fired_arg);
      fails++;
    end
    if (got.last !== e.last) begin
      $display("%0t: last exp %0d got %0d", $time, e.last, got.last);
      fails++;
    end
  endfunction
endclass

module tb_repeating_task_timer_table_unit;
  localparam int CYCLE_LIMIT = 600000;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  rttt_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  rttt_pkg::out_item_t out_item;

  timer_table_scoreboard sb;
  int cycles;
  int results_seen;
  bit hold_done;

  repeating_task_timer_table_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    clk = 0;
    #1;
    clk = 1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(rttt_pkg::op_t op, logic [15:0] tg, logic [31:0] ag,
                      logic [31:0] ivl, logic [15:0] rep, logic [3:0] sl);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push = 0;
      repeat (gap) @(negedge clk);
    end
    push = 1;
    in_item.op = op;
    in_item.task_tag = tg;
    in_item.task_arg = ag;
    in_item.interval = ivl;
    in_item.repeat_count = rep;
    in_item.slot = sl;
    do @(posedge clk); while (full);
    sb.note_transfer(in_item);
    @(negedge clk);
  endtask

  task automatic random_start();
    logic [15:0] tg;
    logic [31:0] ivl;
    logic [15:0] rep;
    tg = 16'($urandom_range(1, 6));
    if ($urandom_range(0, 7) == 0) tg = 16'($urandom());
    ivl = $urandom_range(0, 5);
    if ($urandom_range(0, 15) == 0) ivl = $urandom();
    case ($urandom_range(0, 7))
      0: rep = rttt_pkg::REPEAT_FOREVER;
      1: rep = 16'($urandom());
      default: rep = 16'($urandom_range(0, 4));
    endcase
    send(rttt_pkg::OP_START, tg, $urandom(), ivl, rep, 4'($urandom()));
  endtask

  initial begin
    int r;
    sb = new();
    rst = 1;
    push = 0;
    pop = 0;
    in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(rttt_pkg::OP_START, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    send(rttt_pkg::OP_START, 16'd0, 32'h0, 32'd0, 16'd0, 4'h0);
    send(rttt_pkg::OP_START, 16'd1, 32'h1234_5678, 32'd1, 16'd1, 4'h0);
    send(rttt_pkg::OP_START, 16'd2, 32'hA5A5_5A5A, 32'd2, 16'd3, 4'h0);
    send(rttt_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send(rttt_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send(rttt_pkg::OP_START, 16'd2, 32'h5A5A_A5A5, 32'd0, rttt_pkg::REPEAT_FOREVER, 4'h0);
    send(rttt_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    send(rttt_pkg::OP_CANCEL, 16'd0, 32'd0, 32'd0, 16'd0, 4'hF);
    send(rttt_pkg::OP_CANCEL, 16'd0, 32'd0, 32'd0, 16'd0, 4'd8);
    send(rttt_pkg::OP_CANCEL, 16'd0, 32'd0, 32'd0, 16'd0, 4'd7);
    send(rttt_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    for (int i = 0; i < 9; i++)
      send(rttt_pkg::OP_START, 16'(10 + i), 32'(i), 32'd3, 16'd2, 4'd0);
    send(rttt_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 16'd0, 4'd0);
    for (int i = 0; i < 8; i++)
      send(rttt_pkg::OP_CANCEL, 16'd0, 32'd0, 32'd0, 16'd0, 4'(i));

    for (int n = 0; n < 420; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(rttt_pkg::OP_TICK, 16'($urandom()), $urandom(), $urandom(),
                       16'($urandom()), 4'($urandom()));
      else if (r < 80) random_start();
      else if (r < 95) send(rttt_pkg::OP_CANCEL, 16'($urandom()), $urandom(), $urandom(),
                            16'($urandom()), 4'($urandom_range(0, 15)));
      else send(rttt_pkg::OP_NONE, 16'($urandom()), $urandom(), $urandom(),
                16'($urandom()), 4'($urandom()));
    end
    push = 0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (!hold_done && results_seen >= 60) begin
        hold_done = 1;
        gap = 300;
      end
      if (gap > 0) begin
        pop = 0;
        repeat (gap) @(negedge clk);
      end
      pop = 1;
      do @(posedge clk); while (empty);
      sb.check_result(out_item);
      results_seen++;
      @(negedge clk);
    end
  end
endmodule
